>>> hdl/llti_pkg.sv
// llti_pkg: shared types and constants of the log-log table interpolator
// used by llti_mul, llti_div and log_log_table_interpolator; no dependencies
`default_nettype none

package llti_pkg;

	// item operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INTERP   = 2'd0;
	localparam logic [1:0] ST_CLAMP_LO = 2'd1;
	localparam logic [1:0] ST_CLAMP_HI = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// ln(2) in Q0.64 and one in Q2.62
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

	// longest exponential series
	localparam logic [5:0] TERM_MAX = 6'd40;

	// multiplier request and response
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	// divider request and response: quotient of (num * 2^sh) / den
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  sh;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/llti_mul.sv
// llti_mul: 64x64 to 128-bit multiplier built from one 32x32 partial product a cycle
// depends on llti_pkg for the request and response structs
`default_nettype none

module llti_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire llti_pkg::mul_req_t req,
	output llti_pkg::mul_rsp_t     rsp
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   ppsh_s1;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  ah, bh;
	logic [127:0] pp_ext;

	// pick halves for the current partial product
	always_comb begin
		ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		case (ppsh_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial products and accumulation
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_s1   <= ah * bh;
			ppsh_s1 <= 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]});
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

>>> hdl/llti_div.sv
// llti_div: restoring divider, one quotient bit a cycle, floor(num * 2^sh / den)
// depends on llti_pkg for the request and response structs
`default_nettype none

module llti_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire llti_pkg::div_req_t req,
	output llti_pkg::div_rsp_t     rsp
);

	logic [63:0] dvd_q, den_q, quot_q;
	logic [64:0] rem_q;
	logic [7:0]  cnt_q, last_q;
	logic        busy_q, done_q;
	logic [64:0] r2, rdiff;
	logic        qbit;

	// one restoring step
	always_comb begin
		r2    = {rem_q[63:0], dvd_q[63]};
		qbit  = (r2 >= {1'b0, den_q});
		rdiff = r2 - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 8'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
			last_q <= 8'd63 + 8'(req.sh);
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[62:0], 1'b0};
			rem_q  <= qbit ? rdiff : r2;
			quot_q <= {quot_q[62:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

>>> hdl/llti_table.sv
// llti_table: energy and coefficient memories, one write and one registered read port
// no package dependencies
`default_nettype none

module llti_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [63:0]   wenergy,
	input  wire logic [63:0]   wcoef,
	input  wire logic [AW-1:0] raddr,
	output logic [63:0]        renergy,
	output logic [63:0]        rcoef
);

	logic [63:0] energy_mem [DEPTH];
	logic [63:0] coef_mem   [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			energy_mem[waddr] <= wenergy;
			coef_mem[waddr]   <= wcoef;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		renergy <= energy_mem[raddr];
		rcoef   <= coef_mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/log_log_table_interpolator.sv
// log_log_table_interpolator: table search and log-log interpolation sequencer
// depends on llti_pkg, llti_table, llti_mul and llti_div
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   item     | item_valid / item_stall    | op, entry_index, entry_energy,
//            |                            | entry_coefficient, query_energy
//   result   | result_valid / result_stall| dose_coefficient, status
//   config   | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// a load is written without leaving idle; an empty-table query goes straight to done;
// a clamped query checks the first entry and, above it, the last; an interpolated query
// also scans the entries, takes five logarithms by squaring, a divide and exp2 series terms
// item_stall is high while a query is in work; a finished result waits in the output
// register, so an item is taken while result_stall holds the previous one; arst_n clears
// the sequencer, multiplier and divider control, output valid and used_entries only
`default_nettype none

module log_log_table_interpolator #(
	parameter int TABLE_DEPTH   = 64,
	parameter int LOG_FRAC_BITS = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        op,
	input  wire logic [5:0]  entry_index,
	input  wire logic [63:0] entry_energy,
	input  wire logic [63:0] entry_coefficient,
	input  wire logic [63:0] query_energy,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      dose_coefficient,
	output logic [1:0]       status,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam int F  = LOG_FRAC_BITS;
	localparam int LW = F + 7;

	typedef enum logic [23:0] {
		S_IDLE = 24'h000001,
		S_RD0  = 24'h000002,
		S_CK0  = 24'h000004,
		S_RDN  = 24'h000008,
		S_CKN  = 24'h000010,
		S_RDI  = 24'h000020,
		S_CKI  = 24'h000040,
		S_LOG  = 24'h000080,
		S_NORM = 24'h000100,
		S_MANT = 24'h000200,
		S_SQGO = 24'h000400,
		S_SQW  = 24'h000800,
		S_LEND = 24'h001000,
		S_LCHK = 24'h002000,
		S_DIV  = 24'h004000,
		S_DGO  = 24'h008000,
		S_DW   = 24'h010000,
		S_YGO  = 24'h020000,
		S_YW   = 24'h040000,
		S_TGO  = 24'h080000,
		S_TW   = 24'h100000,
		S_TD   = 24'h200000,
		S_SHF  = 24'h400000,
		S_DONE = 24'h800000
	} state_t;

	state_t state_q, state_d;

	logic [6:0]    used_q;
	logic [NW-1:0] n_c;
	logic [AW-1:0] last_c;
	logic          accept, tbl_we;
	logic [63:0]   renergy, rcoef;

	logic [63:0]   q_q, e1_q, e2_q, h1_q, h2_q;
	logic [AW-1:0] addr_q;
	logic signed [LW-1:0] lq_q, l1_q, l2_q, lh1_q, lh2_q, lh_q;
	logic [2:0]    sel_q, nc_q;
	logic [63:0]   m_q, y_q, term_q, sum_q, res_q;
	logic [5:0]    p_q, rnd_q, ti_q;
	logic [F-1:0]  frac_q;
	logic [F:0]    t_q;
	logic [1:0]    rst_q;
	logic          rv_q;
	logic [63:0]   dose_q;
	logic [1:0]    status_q;

	llti_pkg::mul_req_t mul_req;
	llti_pkg::mul_rsp_t mul_rsp;
	llti_pkg::div_req_t div_req;
	llti_pkg::div_rsp_t div_rsp;

	// entry count clamp and handshake
	assign n_c    = (32'(used_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(used_q);
	assign last_c = AW'(n_c - NW'(1));
	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && !item_stall;
	assign tbl_we = accept && (op == llti_pkg::OP_LOAD) && (32'(entry_index) < TABLE_DEPTH);

	llti_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (AW'(entry_index)),
		.wenergy (entry_energy),
		.wcoef   (entry_coefficient),
		.raddr   (addr_q),
		.renergy (renergy),
		.rcoef   (rcoef)
	);

	llti_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	llti_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// logarithm helpers
	logic [63:0]   log_x;
	logic [63:0]   norm_m;
	logic [5:0]    norm_p;
	logic [63:0]   sq, sq_n;
	logic [6:0]    ip;
	logic signed [LW-1:0] log_val, log_zero;

	always_comb begin
		case (sel_q)
			3'd0:    log_x = q_q;
			3'd1:    log_x = e1_q;
			3'd2:    log_x = e2_q;
			3'd3:    log_x = h1_q;
			default: log_x = h2_q;
		endcase
		// binary search for the leading one
		norm_m = m_q;
		norm_p = p_q;
		case (nc_q)
			3'd0: if (m_q[63:32] == '0) begin norm_m = m_q << 32; norm_p = p_q - 6'd32; end
			3'd1: if (m_q[63:48] == '0) begin norm_m = m_q << 16; norm_p = p_q - 6'd16; end
			3'd2: if (m_q[63:56] == '0) begin norm_m = m_q << 8;  norm_p = p_q - 6'd8;  end
			3'd3: if (m_q[63:60] == '0) begin norm_m = m_q << 4;  norm_p = p_q - 6'd4;  end
			3'd4: if (m_q[63:62] == '0) begin norm_m = m_q << 2;  norm_p = p_q - 6'd2;  end
			default: if (!m_q[63])      begin norm_m = m_q << 1;  norm_p = p_q - 6'd1;  end
		endcase
		sq       = mul_rsp.prod[62 +: 64];
		sq_n     = sq[63] ? (sq >> 1) : sq;
		ip       = 7'({1'b0, p_q}) - 7'd32;
		log_val  = signed'({ip, frac_q});
		log_zero = signed'({7'h60, {F{1'b0}}});
	end

	// interpolation helpers
	logic signed [LW-1:0] lqc;
	logic signed [LW:0]   dnum, dden, dh;
	logic [LW:0]          mag;
	logic [63:0]          dprod;
	logic signed [LW+1:0] lh_new;

	always_comb begin
		if (lq_q < l1_q)
			lqc = l1_q;
		else if (lq_q > l2_q)
			lqc = l2_q;
		else
			lqc = lq_q;
		dnum   = (LW+1)'(lqc) - (LW+1)'(l1_q);
		dden   = (LW+1)'(l2_q) - (LW+1)'(l1_q);
		dh     = (LW+1)'(lh2_q) - (LW+1)'(lh1_q);
		mag    = (dh < 0) ? unsigned'(-dh) : unsigned'(dh);
		dprod  = mul_rsp.prod[F +: 64];
		lh_new = (dh < 0) ? ((LW+2)'(lh1_q) - signed'({1'b0, dprod[LW:0]}))
		                  : ((LW+2)'(lh1_q) + signed'({1'b0, dprod[LW:0]}));
	end

	// final scaling of the exp2 mantissa
	logic signed [6:0] k_c;
	logic signed [7:0] sh_e;
	logic [6:0]        amt;
	logic [63:0]       shifted;

	always_comb begin
		k_c  = lh_q[LW-1:F];
		sh_e = 8'(k_c) - 8'sd30;
		amt  = 7'(sh_e);
		if (sh_e > 8'sd0) begin
			if (sh_e >= 8'sd64 || (sum_q >> (7'd64 - amt)) != '0)
				shifted = '1;
			else
				shifted = sum_q << amt;
		end else if (sh_e <= -8'sd64) begin
			shifted = '0;
		end else begin
			shifted = sum_q >> 7'(-sh_e);
		end
	end

	// shared unit requests
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = m_q;
		mul_req.b     = m_q;
		case (state_q)
			S_SQGO: mul_req.start = 1'b1;
			S_DGO: begin
				mul_req.start = 1'b1;
				mul_req.a     = 64'(mag);
				mul_req.b     = 64'(t_q);
			end
			S_YGO: begin
				mul_req.start = 1'b1;
				mul_req.a     = 64'(lh_q[F-1:0]);
				mul_req.b     = llti_pkg::LN2_Q64;
			end
			S_TGO: begin
				mul_req.start = 1'b1;
				mul_req.a     = term_q;
				mul_req.b     = y_q;
			end
			default: ;
		endcase
		div_req.start = 1'b0;
		div_req.num   = 64'(unsigned'(dnum));
		div_req.den   = 64'(unsigned'(dden));
		div_req.sh    = 7'(F);
		case (state_q)
			S_LCHK: div_req.start = (l2_q > l1_q);
			S_TW: begin
				div_req.start = mul_rsp.done;
				div_req.num   = sq;
				div_req.den   = 64'(ti_q);
				div_req.sh    = 7'd0;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (accept && op == llti_pkg::OP_QUERY)
					state_d = (n_c == '0) ? S_DONE : S_RD0;
			S_RD0: state_d = S_CK0;
			S_CK0: state_d = (q_q <= renergy) ? S_DONE : S_RDN;
			S_RDN: state_d = S_CKN;
			S_CKN: state_d = (q_q >= renergy) ? S_DONE : S_RDI;
			S_RDI: state_d = S_CKI;
			S_CKI:
				if (q_q < renergy || addr_q == last_c)
					state_d = (h1_q == '0 || rcoef == '0) ? S_DONE : S_LOG;
				else
					state_d = S_RDI;
			S_LOG: begin
				if (log_x != '0)
					state_d = S_NORM;
				else if (sel_q == 3'd2)
					state_d = S_LCHK;
				else if (sel_q == 3'd4)
					state_d = S_DGO;
			end
			S_NORM: if (nc_q == 3'd5) state_d = S_MANT;
			S_MANT: state_d = S_SQGO;
			S_SQGO: state_d = S_SQW;
			S_SQW:
				if (mul_rsp.done)
					state_d = (rnd_q == 6'(F - 1)) ? S_LEND : S_SQGO;
			S_LEND: begin
				if (sel_q == 3'd2)
					state_d = S_LCHK;
				else if (sel_q == 3'd4)
					state_d = S_DGO;
				else
					state_d = S_LOG;
			end
			S_LCHK: state_d = (l2_q <= l1_q) ? S_DONE : S_DIV;
			S_DIV:  if (div_rsp.done) state_d = S_LOG;
			S_DGO:  state_d = S_DW;
			S_DW:   if (mul_rsp.done) state_d = S_YGO;
			S_YGO:  state_d = S_YW;
			S_YW:   if (mul_rsp.done) state_d = S_TGO;
			S_TGO:  state_d = S_TW;
			S_TW:   if (mul_rsp.done) state_d = S_TD;
			S_TD:
				if (div_rsp.done) begin
					if (div_rsp.quot == '0 || ti_q == llti_pkg::TERM_MAX)
						state_d = S_SHF;
					else
						state_d = S_TGO;
				end
			S_SHF:  state_d = S_DONE;
			S_DONE: if (!rv_q || !result_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
			used_q  <= 7'd0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready && !paddr[2])
				used_q <= pwdata[6:0];
			if (state_q == S_DONE && (!rv_q || !result_stall))
				rv_q <= 1'b1;
			else if (rv_q && !result_stall)
				rv_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q    <= query_energy;
				addr_q <= '0;
				res_q  <= '0;
				rst_q  <= llti_pkg::ST_EMPTY;
			end
			S_CK0: begin
				e1_q   <= renergy;
				h1_q   <= rcoef;
				res_q  <= rcoef;
				rst_q  <= llti_pkg::ST_CLAMP_LO;
				addr_q <= last_c;
			end
			S_CKN: begin
				res_q  <= rcoef;
				rst_q  <= llti_pkg::ST_CLAMP_HI;
				addr_q <= AW'(1);
			end
			S_CKI: begin
				res_q <= '0;
				rst_q <= llti_pkg::ST_INTERP;
				sel_q <= 3'd0;
				if (q_q < renergy || addr_q == last_c) begin
					e2_q <= renergy;
					h2_q <= rcoef;
				end else begin
					e1_q   <= renergy;
					h1_q   <= rcoef;
					addr_q <= addr_q + AW'(1);
				end
			end
			S_LOG: begin
				m_q    <= log_x;
				p_q    <= 6'd63;
				nc_q   <= 3'd0;
				rnd_q  <= 6'd0;
				frac_q <= '0;
				if (log_x == '0) begin
					case (sel_q)
						3'd0:    lq_q  <= log_zero;
						3'd1:    l1_q  <= log_zero;
						3'd2:    l2_q  <= log_zero;
						3'd3:    lh1_q <= log_zero;
						default: lh2_q <= log_zero;
					endcase
					sel_q <= sel_q + 3'd1;
				end
			end
			S_NORM: begin
				m_q  <= norm_m;
				p_q  <= norm_p;
				nc_q <= nc_q + 3'd1;
			end
			S_MANT: m_q <= m_q >> 1;
			S_SQW:
				if (mul_rsp.done) begin
					m_q    <= sq_n;
					frac_q <= {frac_q[F-2:0], sq[63]};
					rnd_q  <= rnd_q + 6'd1;
				end
			S_LEND: begin
				case (sel_q)
					3'd0:    lq_q  <= log_val;
					3'd1:    l1_q  <= log_val;
					3'd2:    l2_q  <= log_val;
					3'd3:    lh1_q <= log_val;
					default: lh2_q <= log_val;
				endcase
				sel_q <= sel_q + 3'd1;
			end
			S_LCHK: res_q <= h1_q;
			S_DIV:  if (div_rsp.done) t_q <= div_rsp.quot[F:0];
			S_DW:   if (mul_rsp.done) lh_q <= LW'(lh_new);
			S_YW:
				if (mul_rsp.done) begin
					y_q    <= mul_rsp.prod[F+2 +: 64];
					term_q <= llti_pkg::ONE_Q62;
					sum_q  <= llti_pkg::ONE_Q62;
					ti_q   <= 6'd1;
				end
			S_TD:
				if (div_rsp.done && div_rsp.quot != '0) begin
					term_q <= div_rsp.quot;
					sum_q  <= sum_q + div_rsp.quot;
					ti_q   <= ti_q + 6'd1;
				end
			S_SHF:  res_q <= shifted;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rv_q || !result_stall)) begin
			dose_q   <= res_q;
			status_q <= rst_q;
		end
	end

	assign result_valid     = rv_q;
	assign dose_coefficient = dose_q;
	assign status           = status_q;
	assign pready           = 1'b1;
	assign prdata           = paddr[2] ? 32'd0 : {25'd0, used_q};

`ifndef SYNTH
	// multiplier answers only while the sequencer waits on it
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_SQW || state_q == S_DW ||
		                  state_q == S_YW || state_q == S_TW))
		else $error("multiplier result with no waiting step");

	// divider answers only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV || state_q == S_TD))
		else $error("divider result with no waiting step");

	// a finished query lands in a free output register at once
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !rv_q) |=> (rv_q && state_q == S_IDLE))
		else $error("finished result not moved to output");
`endif

endmodule

`default_nettype wire
